>>> src/crc8fr_pkg.sv
// Shared types, constants and the CRC-8 byte update for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package crc8fr_pkg;

  localparam int unsigned LenW = 14;

  localparam logic [7:0]      CrcInit   = 8'hFF;
  localparam logic [7:0]      CrcPoly   = 8'h07;
  localparam logic [LenW-1:0] MaxLenRst = 14'd1024;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_CRC_BAD  = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic            item_kind;
    logic [7:0]      out_byte;
    logic [LenW-1:0] byte_index;
    logic [7:0]      frame_channel;
    logic [LenW-1:0] payload_length;
    logic [1:0]      status;
    logic            frame_end;
  } out_item_t;

  // MSB-first CRC-8 over one byte, no final xor.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/crc8fr_in_stage.sv
// Input register stage: holds one accepted byte until the parser consumes it.
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_in_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire crc8fr_pkg::in_item_t in_item_i,
  input  wire logic                advance_i,
  output logic                     valid_o,
  output crc8fr_pkg::in_item_t     item_o
);

  logic                 valid_q;
  crc8fr_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

>>> src/crc8fr_parser.sv
// Frame parser: header/payload/CRC state, CRC accumulation and result forming.
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_parser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire crc8fr_pkg::in_item_t            item_i,
  input  wire logic                            consume_i,
  input  wire logic [crc8fr_pkg::LenW-1:0]     max_len_i,
  output logic                                 res_valid_o,
  output crc8fr_pkg::out_item_t                res_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC     = 2'd2
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [1:0]                    hdr_cnt_q, hdr_cnt_d;
  logic [7:0]                    len_low_q, len_low_d;
  logic [crc8fr_pkg::LenW-1:0]   frame_len_q, frame_len_d;
  logic [7:0]                    chan_q, chan_d;
  logic [7:0]                    crc_q, crc_d;
  logic [crc8fr_pkg::LenW-1:0]   pay_cnt_q, pay_cnt_d;

  always_comb begin
    phase_e                      ph;
    logic [1:0]                  hc;
    logic [7:0]                  crc;
    logic [crc8fr_pkg::LenW-1:0] pc;
    logic [7:0]                  crc_upd;
    logic [crc8fr_pkg::LenW-1:0] pc_inc;

    ph  = phase_q;
    hc  = hdr_cnt_q;
    crc = crc_q;
    pc  = pay_cnt_q;
    // restart or the unused phase code both resync to a fresh header
    if (item_i.restart || (phase_q != PH_HEADER && phase_q != PH_PAYLOAD
                           && phase_q != PH_CRC)) begin
      ph  = PH_HEADER;
      hc  = 2'd0;
      crc = crc8fr_pkg::CrcInit;
      pc  = '0;
    end
    crc_upd = crc8fr_pkg::crc8_byte(crc, item_i.rx_byte);
    pc_inc  = pc + 1'b1;

    phase_d     = ph;
    hdr_cnt_d   = hc;
    len_low_d   = len_low_q;
    frame_len_d = frame_len_q;
    chan_d      = chan_q;
    crc_d       = crc;
    pay_cnt_d   = pc;

    res_valid_o          = 1'b0;
    res_o.item_kind      = crc8fr_pkg::KIND_STATUS;
    res_o.out_byte       = '0;
    res_o.byte_index     = '0;
    res_o.frame_channel  = chan_q;
    res_o.payload_length = frame_len_q;
    res_o.status         = crc8fr_pkg::STATUS_OK;
    res_o.frame_end      = 1'b1;

    unique case (ph)
      PH_PAYLOAD: begin
        crc_d            = crc_upd;
        res_valid_o      = 1'b1;
        res_o.item_kind  = crc8fr_pkg::KIND_PAYLOAD;
        res_o.out_byte   = item_i.rx_byte;
        res_o.byte_index = pc;
        res_o.frame_end  = 1'b0;
        pay_cnt_d        = pc_inc;
        if (pc_inc >= frame_len_q) begin
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        res_valid_o  = 1'b1;
        res_o.status = (crc == item_i.rx_byte) ? crc8fr_pkg::STATUS_OK
                                               : crc8fr_pkg::STATUS_CRC_BAD;
        phase_d      = PH_HEADER;
        hdr_cnt_d    = 2'd0;
        crc_d        = crc8fr_pkg::CrcInit;
        pay_cnt_d    = '0;
      end
      default: begin
        crc_d = crc_upd;
        unique case (hc)
          2'd0: begin
            len_low_d = item_i.rx_byte;
            hdr_cnt_d = 2'd1;
          end
          2'd1: begin
            // top two bits of the high length byte are ignored
            frame_len_d = {item_i.rx_byte[5:0], len_low_q};
            hdr_cnt_d   = 2'd2;
          end
          2'd2: begin
            chan_d    = item_i.rx_byte;
            hdr_cnt_d = 2'd3;
          end
          default: begin
            hdr_cnt_d = 2'd0;
            pay_cnt_d = '0;
            if (frame_len_q > max_len_i) begin
              res_valid_o  = 1'b1;
              res_o.status = crc8fr_pkg::STATUS_TOO_LONG;
              phase_d      = PH_HEADER;
              crc_d        = crc8fr_pkg::CrcInit;
            end else if (frame_len_q == '0) begin
              phase_d = PH_CRC;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= 2'd0;
      len_low_q   <= '0;
      frame_len_q <= '0;
      chan_q      <= '0;
      crc_q       <= crc8fr_pkg::CrcInit;
      pay_cnt_q   <= '0;
    end else if (consume_i) begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      len_low_q   <= len_low_d;
      frame_len_q <= frame_len_d;
      chan_q      <= chan_d;
      crc_q       <= crc_d;
      pay_cnt_q   <= pay_cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> src/crc8fr_out_stage.sv
// Result register: holds one result item until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire crc8fr_pkg::out_item_t res_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output crc8fr_pkg::out_item_t      out_item_o
);

  logic                  valid_q;
  crc8fr_pkg::out_item_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

>>> src/crc8_frame_receiver.sv
// Top level of the length-prefixed CRC-8 frame receiver.
// Path: a taken byte is held in the input register and parsed from there; its result,
//   if any, is written into the result register when the parser consumes that byte.
// Throughput: one byte per cycle; a held header byte moves on even with the result register
//   full, a byte that makes a result waits until that register frees (same cycle it is taken).
// Reset (rst_ni low, asynchronous): header sync, CRC 0xFF, both stages empty, max length 1024.
`timescale 1ns / 1ps
`default_nettype none

module crc8_frame_receiver (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // byte stream in
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire crc8fr_pkg::in_item_t        in_item_i,
  // payload bytes and status items out
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output crc8fr_pkg::out_item_t            out_item_o,
  // max payload length register
  input  wire logic                        cfg_we_i,
  input  wire logic [crc8fr_pkg::LenW-1:0] cfg_wdata_i
);

  logic [crc8fr_pkg::LenW-1:0] max_len_q;

  logic                  s1_valid;
  crc8fr_pkg::in_item_t  s1_item;
  logic                  res_valid;
  crc8fr_pkg::out_item_t res;
  logic                  out_free;
  logic                  advance;

  // The parser consumes the held byte when it makes no result (header bytes)
  // or when the result register can take the result in this transfer.
  assign advance = s1_valid && (!res_valid || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= crc8fr_pkg::MaxLenRst;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  crc8fr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  crc8fr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (s1_item),
    .consume_i   (advance),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  crc8fr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
